/* rtl/core/twtlc_pkg.sv */
`default_nettype none

package twtlc_pkg;

   localparam int CFG_W        = 16;
   localparam int CSR_ADDR_W   = 3;
   localparam int REM_W        = 16;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 40;
   localparam int RSP_PAD_W    = RSP_DATA_W - 2 * 2 - 2 * REM_W;

   localparam logic [1:0] LAMP_RED    = 2'd0;
   localparam logic [1:0] LAMP_GREEN  = 2'd1;
   localparam logic [1:0] LAMP_YELLOW = 2'd2;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_PRESS = 1'b1;

   localparam logic LIGHT_NS = 1'b0;
   localparam logic LIGHT_WE = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_RED_TIME          = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GREEN_TIME        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_YELLOW_TIME       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BUTTON_GREEN_LEFT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_BUTTON_RED_LEFT   = 3'd4;

   localparam logic [CFG_W-1:0] RED_TIME_RST          = 16'd10000;
   localparam logic [CFG_W-1:0] GREEN_TIME_RST        = 16'd8000;
   localparam logic [CFG_W-1:0] YELLOW_TIME_RST       = 16'd2000;
   localparam logic [CFG_W-1:0] BUTTON_GREEN_LEFT_RST = 16'd2000;
   localparam logic [CFG_W-1:0] BUTTON_RED_LEFT_RST   = 16'd4000;

   localparam logic [REM_W-1:0] REM_MAX = '1;

   typedef struct packed {
      logic [CFG_W-1:0] red_time;
      logic [CFG_W-1:0] green_time;
      logic [CFG_W-1:0] yellow_time;
      logic [CFG_W-1:0] button_green_left;
      logic [CFG_W-1:0] button_red_left;
   } cfg_type;

   typedef struct packed {
      logic tick;
      logic shorten;
      logic set_red;
   } light_ctrl_type;

endpackage

`default_nettype wire

/* rtl/core/twtlc_light.sv */
`default_nettype none

module twtlc_light
   import twtlc_pkg::*;
#(
   parameter int         TIME_BITS  = 16,
   parameter logic [1:0] RESET_LAMP = LAMP_GREEN
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire light_ctrl_type   ctrl,
   input  wire cfg_type          cfg,
   output logic                  press_ok,
   output logic [1:0]            lamp,
   output logic [REM_W-1:0]      remaining
);

   localparam int LIM_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
   localparam int SUM_W = LIM_W + 1;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);
   localparam logic [SUM_W-1:0]     SUM_MAX  = SUM_W'(TIME_MAX);

   logic [1:0]           phase_ff,     phase_in;
   logic [TIME_BITS-1:0] elapsed_ff,   elapsed_in;
   logic [LIM_W-1:0]     green_lim_ff, green_lim_in;
   logic [LIM_W-1:0]     red_lim_ff,   red_lim_in;

   logic [LIM_W-1:0]     yellow_lim;
   logic [LIM_W-1:0]     cur_lim;
   logic [LIM_W-1:0]     next_lim;
   logic [TIME_BITS-1:0] elapsed_inc;
   logic                 phase_end;
   logic [SUM_W-1:0]     green_sum;
   logic [SUM_W-1:0]     red_sum;
   logic [LIM_W-1:0]     green_sat;
   logic [LIM_W-1:0]     red_sat;
   logic [LIM_W-1:0]     rem_diff;

   assign yellow_lim = LIM_W'(cfg.yellow_time);

   always_comb begin
      case (phase_ff)
         LAMP_GREEN:  cur_lim = green_lim_ff;
         LAMP_YELLOW: cur_lim = yellow_lim;
         default:     cur_lim = red_lim_ff;
      endcase
   end

   assign elapsed_inc = (elapsed_ff == TIME_MAX) ? elapsed_ff : elapsed_ff + TIME_ONE;
   assign phase_end   = LIM_W'(elapsed_inc) >= cur_lim;

   assign green_sum = SUM_W'(cfg.button_green_left) + SUM_W'(elapsed_ff);
   assign red_sum   = SUM_W'(cfg.button_red_left) + SUM_W'(elapsed_ff);
   assign green_sat = (green_sum > SUM_MAX) ? LIM_W'(SUM_MAX) : LIM_W'(green_sum);
   assign red_sat   = (red_sum > SUM_MAX) ? LIM_W'(SUM_MAX) : LIM_W'(red_sum);

   assign press_ok = (phase_ff == LAMP_GREEN) && (SUM_W'(green_lim_ff) > green_sum);

   always_comb begin
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      green_lim_in = green_lim_ff;
      red_lim_in   = red_lim_ff;
      if (ctrl.tick) begin
         elapsed_in = elapsed_inc;
         if (phase_end) begin
            elapsed_in = '0;
            case (phase_ff)
               LAMP_GREEN: begin
                  phase_in     = LAMP_YELLOW;
                  green_lim_in = LIM_W'(cfg.green_time);
               end
               LAMP_YELLOW: begin
                  phase_in = LAMP_RED;
               end
               default: begin
                  phase_in   = LAMP_GREEN;
                  red_lim_in = LIM_W'(cfg.red_time);
               end
            endcase
         end
      end
      if (ctrl.shorten) begin
         green_lim_in = green_sat;
      end
      if (ctrl.set_red) begin
         red_lim_in = red_sat;
      end
   end

   always_comb begin
      case (phase_in)
         LAMP_GREEN:  next_lim = green_lim_in;
         LAMP_YELLOW: next_lim = yellow_lim;
         default:     next_lim = red_lim_in;
      endcase
   end

   assign rem_diff  = (next_lim > LIM_W'(elapsed_in)) ? next_lim - LIM_W'(elapsed_in) : '0;
   assign remaining = (rem_diff > LIM_W'(REM_MAX)) ? REM_MAX : rem_diff[REM_W-1:0];
   assign lamp      = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= RESET_LAMP;
         elapsed_ff   <= '0;
         green_lim_ff <= LIM_W'(GREEN_TIME_RST);
         red_lim_ff   <= LIM_W'(RED_TIME_RST);
      end else begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         green_lim_ff <= green_lim_in;
         red_lim_ff   <= red_lim_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/two_way_traffic_light_controller.sv */
// Results are registered; a stalled output sends the new one to the skid stage.
// One request beat per cycle when not stalled; both lights update in one pass.
// A one-beat skid stage behind the result register keeps req_tready up for one
// stalled result; req_tready drops only while that skid stage holds a beat.
// Synchronous reset loads the default timings, north-south green, west-east red,
// elapsed counters zero, and empties the result and skid stages.
`default_nettype none

module two_way_traffic_light_controller
   import twtlc_pkg::*;
#(
   parameter int TIME_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,   // [0] button_light
   input  wire logic                    req_tuser,   // [0] command
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [1:0] ns_lamp, [3:2] we_lamp, [19:4] ns_remaining, [35:20] we_remaining
   output logic [RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                    csr_we,
   input  wire logic [CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [CFG_W-1:0]        csr_wdata
);

   logic [CFG_W-1:0] red_time_ff;
   logic [CFG_W-1:0] green_time_ff;
   logic [CFG_W-1:0] yellow_time_ff;
   logic [CFG_W-1:0] button_green_left_ff;
   logic [CFG_W-1:0] button_red_left_ff;
   cfg_type          cfg;

   logic                  req_accept;
   logic                  cmd_press;
   logic                  who;
   light_ctrl_type        ns_ctrl, we_ctrl;
   logic                  ns_ok, we_ok;
   logic [1:0]            ns_lamp, we_lamp;
   logic [REM_W-1:0]      ns_rem, we_rem;
   logic [RSP_DATA_W-1:0] rsp_data;

   logic                  main_valid_ff, main_valid_in;
   logic [RSP_DATA_W-1:0] main_data_ff,  main_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [RSP_DATA_W-1:0] skid_data_ff,  skid_data_in;
   logic                  pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_time_ff          <= RED_TIME_RST;
         green_time_ff        <= GREEN_TIME_RST;
         yellow_time_ff       <= YELLOW_TIME_RST;
         button_green_left_ff <= BUTTON_GREEN_LEFT_RST;
         button_red_left_ff   <= BUTTON_RED_LEFT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_RED_TIME:          red_time_ff          <= csr_wdata;
            REG_GREEN_TIME:        green_time_ff        <= csr_wdata;
            REG_YELLOW_TIME:       yellow_time_ff       <= csr_wdata;
            REG_BUTTON_GREEN_LEFT: button_green_left_ff <= csr_wdata;
            REG_BUTTON_RED_LEFT:   button_red_left_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.red_time          = red_time_ff;
   assign cfg.green_time        = green_time_ff;
   assign cfg.yellow_time       = yellow_time_ff;
   assign cfg.button_green_left = button_green_left_ff;
   assign cfg.button_red_left   = button_red_left_ff;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign cmd_press  = (req_tuser == CMD_PRESS);
   assign who        = req_tdata[0];

   assign ns_ctrl.tick    = req_accept && !cmd_press;
   assign ns_ctrl.shorten = req_accept && cmd_press && (who == LIGHT_NS) && ns_ok;
   assign ns_ctrl.set_red = req_accept && cmd_press && (who == LIGHT_WE) && we_ok;
   assign we_ctrl.tick    = req_accept && !cmd_press;
   assign we_ctrl.shorten = req_accept && cmd_press && (who == LIGHT_WE) && we_ok;
   assign we_ctrl.set_red = req_accept && cmd_press && (who == LIGHT_NS) && ns_ok;

   twtlc_light #(
      .TIME_BITS  (TIME_BITS),
      .RESET_LAMP (LAMP_GREEN)
   ) u_ns (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ns_ctrl),
      .cfg       (cfg),
      .press_ok  (ns_ok),
      .lamp      (ns_lamp),
      .remaining (ns_rem)
   );

   twtlc_light #(
      .TIME_BITS  (TIME_BITS),
      .RESET_LAMP (LAMP_RED)
   ) u_we (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (we_ctrl),
      .cfg       (cfg),
      .press_ok  (we_ok),
      .lamp      (we_lamp),
      .remaining (we_rem)
   );

   assign rsp_data = {{RSP_PAD_W{1'b0}}, we_rem, ns_rem, we_lamp, ns_lamp};

   // hold a stalled beat in the skid stage, refill the output from it first
   assign pop = !main_valid_ff || rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = req_accept;
            if (req_accept) begin
               main_data_in = rsp_data;
            end
         end
      end else if (req_accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = rsp_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

endmodule

`default_nettype wire

/* rtl/core/twtlc_checker.sv */
`default_nettype none

module twtlc_checker
   import twtlc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed or dropped");

   a_accept_result : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request beat gave no result beat");

   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side stalled with result side empty");

   a_lamp_codes : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == LAMP_RED || rsp_tdata[1:0] == LAMP_GREEN ||
                      rsp_tdata[1:0] == LAMP_YELLOW) &&
                     (rsp_tdata[3:2] == LAMP_RED || rsp_tdata[3:2] == LAMP_GREEN ||
                      rsp_tdata[3:2] == LAMP_YELLOW) &&
                     (rsp_tdata[RSP_DATA_W-1:RSP_DATA_W-RSP_PAD_W] == '0))
      else $error("bad lamp code or nonzero pad bits in result beat");

endmodule

bind two_way_traffic_light_controller twtlc_checker u_twtlc_checker (.*);

`default_nettype wire
